/* rtl/ffv_pkg.sv */
// Shared types, widths and command codes for the sample queue with running variance.
package ffv_pkg;

  localparam int DEPTH      = 64;
  localparam int PTR_W      = 6;
  localparam int CNT_W      = 7;
  localparam int SAMPLE_W   = 16;
  localparam int SUM_W      = 22;
  localparam int SQ_W       = 37;
  localparam int NUM_W      = 43;
  localparam int DEN_W      = 13;
  localparam int SPREAD_W   = 31;
  localparam int DIV_CNT_W  = 6;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 96;

  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_POP   = 2'd1,
    KIND_READ  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_FULL  = 2'd1,
    FAULT_EMPTY = 2'd2
  } fault_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CAPTURE,
    ST_MUL,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_PUBLISH
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic capture;
    logic mul;
    logic div_start;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_busy;
  } sts_t;

endpackage

/* rtl/ffv_div.sv */
// Restoring divider that produces one quotient bit per cycle.
module ffv_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ffv_pkg::NUM_W-1:0]   num,
  input  logic [ffv_pkg::DEN_W-1:0]   den,
  output logic                        done,
  output logic [ffv_pkg::NUM_W-1:0]   quo
);

  logic                             busy_r;
  logic                             done_r;
  logic [ffv_pkg::DIV_CNT_W-1:0]    cnt_r;
  logic [ffv_pkg::DEN_W-1:0]        den_r;
  logic [ffv_pkg::DEN_W-1:0]        rem_r;
  logic [ffv_pkg::NUM_W-1:0]        quo_r;
  logic [ffv_pkg::DEN_W:0]          trial;
  logic                             take;
  logic [ffv_pkg::DEN_W-1:0]        rem_nxt;

  // Bring down the next numerator bit and subtract when the divisor fits.
  always_comb begin
    trial   = {rem_r, quo_r[ffv_pkg::NUM_W-1]};
    take    = (trial >= {1'b0, den_r});
    rem_nxt = take ? ffv_pkg::DEN_W'(trial - {1'b0, den_r})
                   : trial[ffv_pkg::DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == '0)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= ffv_pkg::DIV_CNT_W'(ffv_pkg::NUM_W - 1);
      den_r <= den;
      rem_r <= '0;
      quo_r <= num;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      rem_r <= rem_nxt;
      quo_r <= {quo_r[ffv_pkg::NUM_W-2:0], take};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

/* rtl/ffv_ctrl.sv */
// Sequencing controller: steps one transaction through update, read, multiply and divide.
module ffv_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output ffv_pkg::cmd_t  cmd,
  input  ffv_pkg::sts_t  sts
);

  ffv_pkg::state_t state_r;
  ffv_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffv_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ffv_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ffv_pkg::ST_EXEC;
        end
      end
      ffv_pkg::ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = ffv_pkg::ST_CAPTURE;
      end
      ffv_pkg::ST_CAPTURE: begin
        cmd.capture = 1'b1;
        state_nxt   = ffv_pkg::ST_MUL;
      end
      ffv_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ffv_pkg::ST_DIV_START;
      end
      ffv_pkg::ST_DIV_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = ffv_pkg::ST_DIV_WAIT;
      end
      ffv_pkg::ST_DIV_WAIT: begin
        if (sts.div_done) begin
          state_nxt = ffv_pkg::ST_PUBLISH;
        end
      end
      ffv_pkg::ST_PUBLISH: begin
        if (!sts.out_busy) begin
          cmd.publish = 1'b1;
          state_nxt   = ffv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ffv_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/ffv_dp.sv */
// Datapath: ring store, pointers, running sums, variance operands and the result register.
module ffv_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ffv_pkg::cmd_t                      cmd,
  output ffv_pkg::sts_t                      sts,
  input  logic [ffv_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic [1:0]                         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [ffv_pkg::OUT_DATA_W-1:0]     out_tdata
);

  // Ring store, written and read in a clocked block.
  logic [ffv_pkg::SAMPLE_W-1:0] ring_mem [ffv_pkg::DEPTH];
  logic [ffv_pkg::SAMPLE_W-1:0] rd_data_r;
  logic [ffv_pkg::PTR_W-1:0]    rd_addr;
  logic [ffv_pkg::PTR_W-1:0]    wr_addr;
  logic                         wr_en;

  // Latched transaction.
  ffv_pkg::kind_t               kind_r;
  logic [ffv_pkg::SAMPLE_W-1:0] sample_r;
  logic [ffv_pkg::PTR_W-1:0]    pos_r;

  // Queue state.
  logic [ffv_pkg::PTR_W-1:0]    head_r,  head_nxt;
  logic [ffv_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic signed [ffv_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic [ffv_pkg::SQ_W-1:0]     sq_r,    sq_nxt;
  logic [ffv_pkg::SAMPLE_W-1:0] front_r, front_nxt;
  logic [ffv_pkg::SAMPLE_W-1:0] back_r,  back_nxt;

  // Per-transaction results.
  ffv_pkg::fault_t              fault_r, fault_nxt;
  logic                         rfound_r;
  logic [ffv_pkg::SAMPLE_W-1:0] rval_r;

  // Variance operands.
  logic [ffv_pkg::NUM_W-1:0]    prod_nq_r;
  logic [ffv_pkg::NUM_W-1:0]    prod_ss_r;
  logic [ffv_pkg::DEN_W-1:0]    den_r;
  logic [ffv_pkg::NUM_W-1:0]    quo;
  logic                         div_done;

  // Result register.
  logic                           out_valid_r;
  logic [ffv_pkg::OUT_DATA_W-1:0] out_data_r;

  logic [ffv_pkg::SAMPLE_W-1:0]   samp_sel;
  logic [ffv_pkg::SAMPLE_W-1:0]   samp_mag;
  logic [2*ffv_pkg::SAMPLE_W-1:0] samp_sq;
  logic signed [ffv_pkg::SUM_W-1:0] samp_ext;
  logic [ffv_pkg::SUM_W-1:0]      sum_mag;
  logic                           is_full;
  logic                           is_empty;
  logic                           pos_found;
  logic [ffv_pkg::SPREAD_W-1:0]   spread;
  logic                           empty_now;

  // Push adds the new sample; pop removes the current front.
  always_comb begin
    samp_sel = (kind_r == ffv_pkg::KIND_PUSH) ? sample_r : front_r;
    samp_mag = samp_sel[ffv_pkg::SAMPLE_W-1] ? ffv_pkg::SAMPLE_W'(~samp_sel + 1'b1)
                                             : samp_sel;
    samp_sq  = (2*ffv_pkg::SAMPLE_W)'(samp_mag) * (2*ffv_pkg::SAMPLE_W)'(samp_mag);
    samp_ext = ffv_pkg::SUM_W'(signed'(samp_sel));
    is_full  = (count_r == ffv_pkg::CNT_W'(ffv_pkg::DEPTH));
    is_empty = (count_r == '0);
    pos_found = (ffv_pkg::CNT_W'(pos_r) < count_r);
    wr_addr  = head_r + count_r[ffv_pkg::PTR_W-1:0];
    rd_addr  = (kind_r == ffv_pkg::KIND_POP) ? ffv_pkg::PTR_W'(head_r + 1'b1)
                                             : ffv_pkg::PTR_W'(head_r + pos_r);
  end

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    sum_nxt   = sum_r;
    sq_nxt    = sq_r;
    front_nxt = front_r;
    back_nxt  = back_r;
    fault_nxt = ffv_pkg::FAULT_NONE;
    wr_en     = 1'b0;
    unique case (kind_r)
      ffv_pkg::KIND_PUSH: begin
        if (is_full) begin
          fault_nxt = ffv_pkg::FAULT_FULL;
        end else begin
          wr_en     = 1'b1;
          count_nxt = count_r + 1'b1;
          sum_nxt   = sum_r + samp_ext;
          sq_nxt    = sq_r + ffv_pkg::SQ_W'(samp_sq);
          back_nxt  = sample_r;
          if (is_empty) begin
            front_nxt = sample_r;
          end
        end
      end
      ffv_pkg::KIND_POP: begin
        if (is_empty) begin
          fault_nxt = ffv_pkg::FAULT_EMPTY;
        end else begin
          count_nxt = count_r - 1'b1;
          sum_nxt   = sum_r - samp_ext;
          sq_nxt    = sq_r - ffv_pkg::SQ_W'(samp_sq);
          // An emptied queue restarts at slot zero.
          head_nxt  = (count_r == ffv_pkg::CNT_W'(1)) ? '0 : ffv_pkg::PTR_W'(head_r + 1'b1);
        end
      end
      ffv_pkg::KIND_READ: begin
      end
      ffv_pkg::KIND_CLEAR: begin
        head_nxt  = '0;
        count_nxt = '0;
        sum_nxt   = '0;
        sq_nxt    = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en && cmd.exec) begin
      ring_mem[wr_addr] <= sample_r;
    end
    if (cmd.exec) begin
      rd_data_r <= ring_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      sum_r   <= '0;
      sq_r    <= '0;
    end else if (cmd.exec) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      sq_r    <= sq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r   <= ffv_pkg::kind_t'(in_tuser);
      sample_r <= in_tdata[ffv_pkg::SAMPLE_W-1:0];
      pos_r    <= in_tdata[ffv_pkg::SAMPLE_W +: ffv_pkg::PTR_W];
    end
    if (cmd.exec) begin
      front_r  <= front_nxt;
      back_r   <= back_nxt;
      fault_r  <= fault_nxt;
      rfound_r <= (kind_r == ffv_pkg::KIND_READ) && pos_found;
    end
    if (cmd.capture) begin
      rval_r <= rfound_r ? rd_data_r : '0;
      // After a pop the next-oldest sample becomes the front.
      if ((kind_r == ffv_pkg::KIND_POP) && (fault_r == ffv_pkg::FAULT_NONE)) begin
        front_r <= rd_data_r;
      end
    end
  end

  assign sum_mag = sum_r[ffv_pkg::SUM_W-1] ? ffv_pkg::SUM_W'(-sum_r) : ffv_pkg::SUM_W'(sum_r);

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_nq_r <= ffv_pkg::NUM_W'(count_r) * ffv_pkg::NUM_W'(sq_r);
      prod_ss_r <= ffv_pkg::NUM_W'((2*ffv_pkg::SUM_W)'(sum_mag) *
                                   (2*ffv_pkg::SUM_W)'(sum_mag));
      den_r     <= ffv_pkg::DEN_W'(count_r) * ffv_pkg::DEN_W'(count_r);
    end
  end

  ffv_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (prod_nq_r - prod_ss_r),
    .den   (den_r),
    .done  (div_done),
    .quo   (quo)
  );

  always_comb begin
    empty_now = (count_r == '0);
    if (empty_now) begin
      spread = '0;
    end else if (quo[ffv_pkg::NUM_W-1:ffv_pkg::SPREAD_W] != '0) begin
      spread = '1;
    end else begin
      spread = quo[ffv_pkg::SPREAD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.publish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_data_r <= {6'd0, fault_r, rfound_r, rval_r, spread, empty_now, count_r,
                     empty_now ? '0 : back_r, empty_now ? '0 : front_r};
    end
  end

  assign sts.div_done = div_done;
  assign sts.out_busy = out_valid_r && !out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;

endmodule

/* rtl/fifo_with_window_variance.sv */
// Top level of the bounded sample queue that reports the variance of its contents.
// Each transaction is loaded, applied to the queue, captured, multiplied and then divided
// by the one-bit-per-cycle restoring divider that forms the variance quotient.
// One transaction is handled at a time; the next input is taken once the
// result has moved into the output register, even while that result waits there.
// Reset (rst_n low, synchronous) empties the queue and clears both running sums;
// the ring store itself is not cleared, since only written entries are ever read.
module fifo_with_window_variance (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input transaction channel.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ffv_pkg::IN_DATA_W-1:0]     in_tdata,  // sample[15:0], position[21:16], zero pad
  input  logic [1:0]                        in_tuser,  // kind[1:0]
  // Result transaction channel.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // front_value[15:0], back_value[31:16], item_count[38:32], is_empty[39],
  // spread[70:40], read_value[86:71], read_found[87], fault[89:88], zero pad
  output logic [ffv_pkg::OUT_DATA_W-1:0]    out_tdata
);

  ffv_pkg::cmd_t cmd;
  ffv_pkg::sts_t sts;

  // The controller walks each transaction through its steps; the datapath holds
  // every piece of queue state and the result register.
  ffv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  ffv_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

`ifndef SYNTHESIS
  // Only one transaction is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while a transaction was still in flight");

  // The reported count never exceeds the queue depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[38:32] <= 7'(ffv_pkg::DEPTH)))
    else $error("item count above queue depth");

  // The empty flag agrees with the count.
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[39] == (out_tdata[38:32] == '0)))
    else $error("empty flag disagrees with item count");

  // An empty queue reports zero front, back and variance.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[39]) |-> ((out_tdata[31:0] == '0) && (out_tdata[70:40] == '0)))
    else $error("empty queue reported nonzero front, back or variance");

  // A dropped push is only reported when the queue is full.
  a_full_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[89:88] == ffv_pkg::FAULT_FULL))
      |-> (out_tdata[38:32] == 7'(ffv_pkg::DEPTH)))
    else $error("push dropped while queue was not full");
`endif

endmodule
